>>> rtl/ptscu_pkg.sv
// Shared types and constants for the pan/tilt stepper command unit.
// Used by the front end, the op queue, the back end and the top level.
// Depends on nothing.
package ptscu_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned STEP_W   = (POS_W > 16) ? POS_W : 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_POS_W = 16;
  localparam int unsigned LED_W    = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_STEPS    = 3'd0,
    CFG_AUTO_HALF     = 3'd1,
    CFG_MANUAL_STEPS  = 3'd2,
    CFG_MANUAL_HALF   = 3'd3,
    CFG_HOME_HALF     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Z = 1'b1
  } axis_e;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_MANUAL = 3'd1,
    OP_TRACK  = 3'd2,
    OP_HOME   = 3'd3,
    OP_LED    = 3'd4,
    OP_NONE   = 3'd5
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    axis_e            man_axis;
    logic             man_dir;
    logic             trk_x_en;
    logic             trk_x_pos;
    logic             trk_z_en;
    logic             trk_z_pos;
    logic [LED_W-1:0] led;
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0] auto_steps;
    logic [CFG_W-1:0] auto_half;
    logic [CFG_W-1:0] manual_steps;
    logic [CFG_W-1:0] manual_half;
    logic [CFG_W-1:0] home_half;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic                        x_step;
    logic                        x_dir;
    logic                        z_step;
    logic                        z_dir;
    logic [LED_W-1:0]            led;
    logic                        busy;
    logic                        dropped;
    logic signed [OUT_POS_W-1:0] x_pos;
    logic signed [OUT_POS_W-1:0] z_pos;
  } res_t;

endpackage

>>> rtl/ptscu_front.sv
// Front end: takes input beats and classifies them into queue ops.
// Depends on ptscu_pkg.
module ptscu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  logic [7:0]     cmd_byte_i,
  output logic           op_valid_o,
  output ptscu_pkg::op_t op_o,
  input  logic           op_ready_i
);

  localparam logic [7:0] ChU = 8'h55;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChJ = 8'h4A;
  localparam logic [7:0] ChW = 8'h57;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChK = 8'h4B;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChL = 8'h4C;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChY = 8'h59;
  localparam logic [7:0] ChZ = 8'h5A;

  logic           valid_q, valid_d;
  ptscu_pkg::op_t op_q, op_d;
  logic           take;

  function automatic ptscu_pkg::op_t track(logic xe, logic xp, logic ze, logic zp);
    ptscu_pkg::op_t o;
    o = '0;
    o.kind = ptscu_pkg::OP_TRACK;
    o.trk_x_en = xe;
    o.trk_x_pos = xp;
    o.trk_z_en = ze;
    o.trk_z_pos = zp;
    return o;
  endfunction

  function automatic ptscu_pkg::op_t manual(ptscu_pkg::axis_e ax, logic dir);
    ptscu_pkg::op_t o;
    o = '0;
    o.kind = ptscu_pkg::OP_MANUAL;
    o.man_axis = ax;
    o.man_dir = dir;
    return o;
  endfunction

  function automatic ptscu_pkg::op_t led(int unsigned bit_idx);
    ptscu_pkg::op_t o;
    o = '0;
    o.kind = ptscu_pkg::OP_LED;
    o.led = ptscu_pkg::LED_W'(1) << bit_idx;
    return o;
  endfunction

  function automatic ptscu_pkg::op_t decode(logic [7:0] c);
    ptscu_pkg::op_t o;
    o = '0;
    o.kind = ptscu_pkg::OP_NONE;
    case (c)
      ChU: o = manual(ptscu_pkg::AXIS_Z, 1'b1);
      ChO: o = manual(ptscu_pkg::AXIS_Z, 1'b0);
      ChJ: o = manual(ptscu_pkg::AXIS_X, 1'b0);
      ChW: o = manual(ptscu_pkg::AXIS_X, 1'b1);
      ChC: o = track(1'b1, 1'b1, 1'b1, 1'b1);
      ChB: o = track(1'b0, 1'b0, 1'b1, 1'b1);
      ChA: o = track(1'b1, 1'b0, 1'b1, 1'b1);
      ChF: o = track(1'b1, 1'b1, 1'b0, 1'b0);
      ChD: o = track(1'b1, 1'b0, 1'b0, 1'b0);
      ChK: o = track(1'b1, 1'b1, 1'b1, 1'b0);
      ChH: o = track(1'b0, 1'b0, 1'b1, 1'b0);
      ChG: o = track(1'b1, 1'b0, 1'b1, 1'b0);
      ChI: o.kind = ptscu_pkg::OP_HOME;
      ChM: o = led(0);
      ChN: o = led(1);
      ChS: o = led(2);
      ChL: o = led(3);
      ChR: o = led(4);
      ChP: o = led(5);
      ChT: o = led(6);
      ChY: o = led(7);
      ChZ: o = led(8);
      default: o.kind = ptscu_pkg::OP_NONE;
    endcase
    return o;
  endfunction

  assign in_ready_o = !valid_q || op_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (take) begin
      valid_d = 1'b1;
      if (req_type_i) begin
        op_d      = '0;
        op_d.kind = ptscu_pkg::OP_TICK;
      end else begin
        op_d = decode(cmd_byte_i);
      end
    end else if (op_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

>>> rtl/ptscu_fifo.sv
// Two-entry queue of classified ops between the front end and the back end.
// Depends on ptscu_pkg.
module ptscu_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ptscu_pkg::op_t        data_i,
  input  logic                  pop_i,
  output ptscu_pkg::op_t        data_o,
  output ptscu_pkg::fifo_stat_t stat_o
);

  ptscu_pkg::op_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/ptscu_back.sv
// Back end: carries out ops against the motion state and registers results.
// Depends on ptscu_pkg.
module ptscu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptscu_pkg::cfg_t cfg_i,
  input  logic            op_valid_i,
  input  ptscu_pkg::op_t  op_i,
  output logic            op_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ptscu_pkg::res_t res_o
);

  localparam int unsigned PW = ptscu_pkg::POS_W;
  localparam int unsigned SW = ptscu_pkg::STEP_W;
  localparam logic [PW-1:0] PosTop = {1'b1, {(PW-1){1'b0}}};

  logic [PW-1:0]  pan_pos_q, pan_pos_d, tilt_pos_q, tilt_pos_d;
  logic [ptscu_pkg::LED_W-1:0] led_q, led_d;
  logic           pan_dir_q, pan_dir_d, tilt_dir_q, tilt_dir_d;
  logic           seg_axis_q [2];
  logic           seg_axis_d [2];
  logic           seg_dir_q [2];
  logic           seg_dir_d [2];
  logic [SW-1:0]  seg_steps_q [2];
  logic [SW-1:0]  seg_steps_d [2];
  logic [1:0]     seg_total_q, seg_total_d;
  logic [1:0]     seg_idx_q, seg_idx_d;
  logic           moving_q, moving_d;
  logic [SW-1:0]  steps_q, steps_d;
  logic [15:0]    hp_q, hp_d;
  logic [15:0]    half_q, half_d;
  logic           phase_q, phase_d;
  logic           out_valid_q;
  ptscu_pkg::res_t res_q, res_d;

  logic           pop;
  logic           dropped;
  logic           start_run;
  logic           found;
  logic [1:0]     run_idx;
  logic [15:0]    half_sel;
  logic [PW-1:0]  n_pos;
  logic           xn, zn;
  logic [PW-1:0]  xs, zs;
  logic           cur_axis;

  assign pop      = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_pop_o = pop;

  assign n_pos = PW'(cfg_i.auto_steps);
  assign xn    = pan_pos_q[PW-1] && (pan_pos_q != PosTop);
  assign zn    = tilt_pos_q[PW-1] && (tilt_pos_q != PosTop);
  assign xs    = xn ? (PW'(0) - pan_pos_q) : pan_pos_q;
  assign zs    = zn ? (PW'(0) - tilt_pos_q) : tilt_pos_q;

  always_comb begin
    pan_pos_d   = pan_pos_q;
    tilt_pos_d  = tilt_pos_q;
    led_d       = led_q;
    pan_dir_d   = pan_dir_q;
    tilt_dir_d  = tilt_dir_q;
    seg_axis_d  = seg_axis_q;
    seg_dir_d   = seg_dir_q;
    seg_steps_d = seg_steps_q;
    seg_total_d = seg_total_q;
    seg_idx_d   = seg_idx_q;
    moving_d    = moving_q;
    steps_d     = steps_q;
    hp_d        = hp_q;
    half_d      = half_q;
    phase_d     = phase_q;
    dropped     = 1'b0;
    start_run   = 1'b0;
    run_idx     = 2'd0;
    half_sel    = half_q;
    found       = 1'b0;

    if (pop) begin
      if (op_i.kind == ptscu_pkg::OP_TICK) begin
        if (moving_q) begin
          hp_d = (hp_q != 16'd0) ? hp_q - 16'd1 : hp_q;
          if (hp_d == 16'd0) begin
            if (phase_q) begin
              phase_d = 1'b0;
              hp_d    = half_q;
            end else begin
              steps_d = steps_q - SW'(1);
              if (steps_d != '0) begin
                phase_d = 1'b1;
                hp_d    = half_q;
              end else begin
                start_run = 1'b1;
                run_idx   = seg_idx_q + 2'd1;
              end
            end
          end
        end
      end else if (moving_q) begin
        dropped = 1'b1;
      end else begin
        case (op_i.kind)
          ptscu_pkg::OP_MANUAL: begin
            seg_total_d    = 2'd1;
            seg_axis_d[0]  = op_i.man_axis;
            seg_dir_d[0]   = op_i.man_dir;
            seg_steps_d[0] = SW'(cfg_i.manual_steps);
            half_sel       = cfg_i.manual_half;
            start_run      = 1'b1;
          end
          ptscu_pkg::OP_TRACK: begin
            if (op_i.trk_z_en) begin
              tilt_pos_d = op_i.trk_z_pos ? tilt_pos_q + n_pos : tilt_pos_q - n_pos;
            end
            if (op_i.trk_x_en) begin
              pan_pos_d = op_i.trk_x_pos ? pan_pos_q + n_pos : pan_pos_q - n_pos;
            end
            seg_total_d    = (op_i.trk_z_en && op_i.trk_x_en) ? 2'd2 : 2'd1;
            seg_axis_d[0]  = op_i.trk_z_en ? ptscu_pkg::AXIS_Z : ptscu_pkg::AXIS_X;
            seg_dir_d[0]   = op_i.trk_z_en ? op_i.trk_z_pos : op_i.trk_x_pos;
            seg_steps_d[0] = SW'(cfg_i.auto_steps);
            seg_axis_d[1]  = ptscu_pkg::AXIS_X;
            seg_dir_d[1]   = op_i.trk_x_pos;
            seg_steps_d[1] = SW'(cfg_i.auto_steps);
            half_sel       = cfg_i.auto_half;
            start_run      = 1'b1;
          end
          ptscu_pkg::OP_HOME: begin
            seg_total_d = 2'd2;
            if (!xn && zn) begin
              seg_axis_d[0]  = ptscu_pkg::AXIS_Z;
              seg_dir_d[0]   = 1'b1;
              seg_steps_d[0] = SW'(zs);
              seg_axis_d[1]  = ptscu_pkg::AXIS_X;
              seg_dir_d[1]   = 1'b0;
              seg_steps_d[1] = SW'(xs);
            end else begin
              seg_axis_d[0]  = ptscu_pkg::AXIS_X;
              seg_dir_d[0]   = xn;
              seg_steps_d[0] = SW'(xs);
              seg_axis_d[1]  = ptscu_pkg::AXIS_Z;
              seg_dir_d[1]   = zn;
              seg_steps_d[1] = SW'(zs);
            end
            pan_pos_d  = '0;
            tilt_pos_d = '0;
            half_sel   = cfg_i.home_half;
            start_run  = 1'b1;
          end
          ptscu_pkg::OP_LED: begin
            led_d = op_i.led;
          end
          default: begin
          end
        endcase
        if (start_run) begin
          half_d = (half_sel == 16'd0) ? 16'd1 : half_sel;
        end
      end

      if (start_run) begin
        for (int s = 0; s < 2; s++) begin
          if (!found && (run_idx == 2'(s)) && (2'(s) < seg_total_d)) begin
            if (seg_axis_d[s] == ptscu_pkg::AXIS_X) begin
              pan_dir_d = seg_dir_d[s];
            end else begin
              tilt_dir_d = seg_dir_d[s];
            end
            if (seg_steps_d[s] != '0) begin
              found   = 1'b1;
              steps_d = seg_steps_d[s];
              phase_d = 1'b1;
              hp_d    = half_d;
            end else begin
              run_idx = run_idx + 2'd1;
            end
          end
        end
        seg_idx_d = run_idx;
        moving_d  = found;
        if (!found) begin
          phase_d = 1'b0;
          steps_d = '0;
          hp_d    = 16'd0;
        end
      end
    end

    cur_axis        = seg_axis_d[seg_idx_d[0]];
    res_d.x_step    = moving_d && phase_d && (cur_axis == ptscu_pkg::AXIS_X);
    res_d.z_step    = moving_d && phase_d && (cur_axis == ptscu_pkg::AXIS_Z);
    res_d.x_dir     = pan_dir_d;
    res_d.z_dir     = tilt_dir_d;
    res_d.led       = led_d;
    res_d.busy      = moving_d;
    res_d.dropped   = dropped;
    res_d.x_pos     = ptscu_pkg::OUT_POS_W'($signed(pan_pos_d));
    res_d.z_pos     = ptscu_pkg::OUT_POS_W'($signed(tilt_pos_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_pos_q   <= '0;
      tilt_pos_q  <= '0;
      led_q       <= '0;
      pan_dir_q   <= 1'b0;
      tilt_dir_q  <= 1'b0;
      seg_total_q <= 2'd0;
      seg_idx_q   <= 2'd0;
      moving_q    <= 1'b0;
      steps_q     <= '0;
      hp_q        <= 16'd0;
      half_q      <= 16'd1;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pan_pos_q   <= pan_pos_d;
      tilt_pos_q  <= tilt_pos_d;
      led_q       <= led_d;
      pan_dir_q   <= pan_dir_d;
      tilt_dir_q  <= tilt_dir_d;
      seg_total_q <= seg_total_d;
      seg_idx_q   <= seg_idx_d;
      moving_q    <= moving_d;
      steps_q     <= steps_d;
      hp_q        <= hp_d;
      half_q      <= half_d;
      phase_q     <= phase_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_axis_q  <= seg_axis_d;
    seg_dir_q   <= seg_dir_d;
    seg_steps_q <= seg_steps_d;
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/pan_tilt_stepper_command_unit.sv
// Top level of the pan/tilt stepper command unit: configuration registers,
// front end, op queue and back end. Depends on ptscu_pkg and its submodules.
// An accepted beat passes through the front-end register, the op queue and the back-end
// result register before its result is valid. Throughput: one beat per cycle while the
// result output is not stalled. Reset: asynchronous, active low; clears the valid flags,
// queue pointers, positions and motion counters and loads the default configuration; no clearing pass is needed.
module pan_tilt_stepper_command_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 req_type_i,
  input  logic [7:0]                           cmd_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 x_step_o,
  output logic                                 x_dir_o,
  output logic                                 z_step_o,
  output logic                                 z_dir_o,
  output logic [ptscu_pkg::LED_W-1:0]          led_pattern_o,
  output logic                                 busy_res_o,
  output logic                                 cmd_dropped_o,
  output logic signed [ptscu_pkg::OUT_POS_W-1:0] x_position_o,
  output logic signed [ptscu_pkg::OUT_POS_W-1:0] z_position_o,
  input  logic                                 cfg_we_i,
  input  logic [ptscu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ptscu_pkg::CFG_W-1:0]          cfg_wdata_i
);

  ptscu_pkg::cfg_t       cfg_q;
  logic                  f_valid;
  ptscu_pkg::op_t        f_op;
  ptscu_pkg::op_t        q_op;
  ptscu_pkg::fifo_stat_t q_stat;
  logic                  q_pop;
  ptscu_pkg::res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_steps   <= 16'd30;
      cfg_q.auto_half    <= 16'd1000;
      cfg_q.manual_steps <= 16'd100;
      cfg_q.manual_half  <= 16'd1000;
      cfg_q.home_half    <= 16'd400;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptscu_pkg::CFG_AUTO_STEPS:   cfg_q.auto_steps   <= cfg_wdata_i;
        ptscu_pkg::CFG_AUTO_HALF:    cfg_q.auto_half    <= cfg_wdata_i;
        ptscu_pkg::CFG_MANUAL_STEPS: cfg_q.manual_steps <= cfg_wdata_i;
        ptscu_pkg::CFG_MANUAL_HALF:  cfg_q.manual_half  <= cfg_wdata_i;
        ptscu_pkg::CFG_HOME_HALF:    cfg_q.home_half    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ptscu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .cmd_byte_i (cmd_byte_i),
    .op_valid_o (f_valid),
    .op_o       (f_op),
    .op_ready_i (!q_stat.full)
  );

  ptscu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .data_i (f_op),
    .pop_i  (q_pop),
    .data_o (q_op),
    .stat_o (q_stat)
  );

  ptscu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (!q_stat.empty),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign x_step_o      = res.x_step;
  assign x_dir_o       = res.x_dir;
  assign z_step_o      = res.z_step;
  assign z_dir_o       = res.z_dir;
  assign led_pattern_o = res.led;
  assign busy_res_o    = res.busy;
  assign cmd_dropped_o = res.dropped;
  assign x_position_o  = res.x_pos;
  assign z_position_o  = res.z_pos;

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("Queue reports full and empty at once.");

  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(x_step_o && z_step_o))
    else $error("Both axes pulse in the same result.");

  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmd_dropped_o) |-> busy_res_o)
    else $error("A command was dropped while the unit was idle.");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (x_step_o || z_step_o)) |-> busy_res_o)
    else $error("Step pulse high while the unit is idle.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("Back end took an op from an empty queue.");

endmodule

>>> verif/pan_tilt_stepper_command_unit_test.sv
// Self-checking testbench for pan_tilt_stepper_command_unit: queued command and tick beats,
// a status predictor of the pan/tilt motion, and a field-by-field status check.
// Depends on ptscu_pkg and the pan_tilt_stepper_command_unit RTL.
module pan_tilt_stepper_command_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic DIR_POS = 1'b1;
  localparam logic DIR_NEG = 1'b0;

  localparam logic [7:0] CMD_TILT_UP    = "U";
  localparam logic [7:0] CMD_TILT_DOWN  = "O";
  localparam logic [7:0] CMD_PAN_LEFT   = "J";
  localparam logic [7:0] CMD_PAN_RIGHT  = "W";
  localparam logic [7:0] CMD_UP_RIGHT   = "C";
  localparam logic [7:0] CMD_UP         = "B";
  localparam logic [7:0] CMD_UP_LEFT    = "A";
  localparam logic [7:0] CMD_RIGHT      = "F";
  localparam logic [7:0] CMD_LEFT       = "D";
  localparam logic [7:0] CMD_DOWN_RIGHT = "K";
  localparam logic [7:0] CMD_DOWN       = "H";
  localparam logic [7:0] CMD_DOWN_LEFT  = "G";
  localparam logic [7:0] CMD_HOME       = "I";
  localparam logic [7:0] CMD_LED_0      = "M";
  localparam logic [7:0] CMD_LED_1      = "N";
  localparam logic [7:0] CMD_LED_2      = "S";
  localparam logic [7:0] CMD_LED_3      = "L";
  localparam logic [7:0] CMD_LED_4      = "R";
  localparam logic [7:0] CMD_LED_5      = "P";
  localparam logic [7:0] CMD_LED_6      = "T";
  localparam logic [7:0] CMD_LED_7      = "Y";
  localparam logic [7:0] CMD_LED_8      = "Z";

  localparam logic [7:0] BYTE_UNKNOWN_LOW   = 8'h00;
  localparam logic [7:0] BYTE_UNKNOWN_HIGH  = 8'hFF;
  localparam logic [7:0] BYTE_UNKNOWN_LOWER = "u";

  localparam logic [ptscu_pkg::POS_W-1:0] POS_MOST_NEG =
    {1'b1, {(ptscu_pkg::POS_W-1){1'b0}}};
  localparam logic [ptscu_pkg::LED_W-1:0] LED_FIRST = ptscu_pkg::LED_W'(1);

  localparam int DRAIN_CYCLES            = 12;
  localparam int BEATS_PER_SETTING       = 60;
  localparam int CYCLE_LIMIT             = 200_000;

  typedef struct {
    logic            req;
    logic [7:0]      cmd;
    ptscu_pkg::res_t want;
  } cmd_tick_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = REQ_TICK;
  logic [7:0] cmd_byte_i = BYTE_UNKNOWN_LOW;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic x_step_o;
  logic x_dir_o;
  logic z_step_o;
  logic z_dir_o;
  logic [ptscu_pkg::LED_W-1:0] led_pattern_o;
  logic busy_res_o;
  logic cmd_dropped_o;
  logic signed [ptscu_pkg::OUT_POS_W-1:0] x_position_o;
  logic signed [ptscu_pkg::OUT_POS_W-1:0] z_position_o;
  logic cfg_we_i = 1'b0;
  logic [ptscu_pkg::CFG_IDX_W-1:0] cfg_idx_i = ptscu_pkg::CFG_AUTO_STEPS;
  logic [ptscu_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  cmd_tick_t cmd_tick_q [$];
  ptscu_pkg::res_t status_due [$];
  ptscu_pkg::res_t in_expected;
  logic in_beat_taken = 1'b0;

  int gap_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int status_checked = 0;
  int cmds_queued = 0;
  int drops_queued = 0;
  int live_beats = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  ptscu_pkg::cfg_t regs;
  logic [ptscu_pkg::POS_W-1:0] pan_pos;
  logic [ptscu_pkg::POS_W-1:0] tilt_pos;
  logic [ptscu_pkg::LED_W-1:0] led_on;
  logic pan_dir;
  logic tilt_dir;
  ptscu_pkg::axis_e seg_axis [2];
  logic seg_dir [2];
  logic [16:0] seg_len [2];
  int seg_count;
  int seg_idx;
  logic moving;
  logic [16:0] steps_left;
  logic [16:0] half_left;
  logic [16:0] half_len;
  logic pulse_high;

  pan_tilt_stepper_command_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .cmd_byte_i    (cmd_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_step_o      (x_step_o),
    .x_dir_o       (x_dir_o),
    .z_step_o      (z_step_o),
    .z_dir_o       (z_dir_o),
    .led_pattern_o (led_pattern_o),
    .busy_res_o    (busy_res_o),
    .cmd_dropped_o (cmd_dropped_o),
    .x_position_o  (x_position_o),
    .z_position_o  (z_position_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_motion_model();
    regs = '{auto_steps: 16'd30, auto_half: 16'd1000, manual_steps: 16'd100,
             manual_half: 16'd1000, home_half: 16'd400};
    pan_pos = '0;
    tilt_pos = '0;
    led_on = '0;
    pan_dir = DIR_NEG;
    tilt_dir = DIR_NEG;
    for (int i = 0; i < 2; i++) begin
      seg_axis[i] = ptscu_pkg::AXIS_X;
      seg_dir[i] = DIR_NEG;
      seg_len[i] = '0;
    end
    seg_count = 0;
    seg_idx = 0;
    moving = 1'b0;
    steps_left = '0;
    half_left = '0;
    half_len = 17'd1;
    pulse_high = 1'b0;
  endfunction

  function automatic void add_segment(ptscu_pkg::axis_e axis, logic dir, logic [16:0] steps);
    if (seg_count < 2) begin
      seg_axis[seg_count] = axis;
      seg_dir[seg_count] = dir;
      seg_len[seg_count] = steps;
      seg_count++;
    end
  endfunction

  // Zero-step segments still set their axis direction before being skipped.
  function automatic void start_segment();
    while (seg_idx < seg_count) begin
      if (seg_axis[seg_idx] == ptscu_pkg::AXIS_X) begin
        pan_dir = seg_dir[seg_idx];
      end else begin
        tilt_dir = seg_dir[seg_idx];
      end
      if (seg_len[seg_idx] != 0) begin
        moving = 1'b1;
        steps_left = seg_len[seg_idx];
        pulse_high = 1'b1;
        half_left = half_len;
        return;
      end
      seg_idx++;
    end
    moving = 1'b0;
    pulse_high = 1'b0;
    steps_left = '0;
    half_left = '0;
  endfunction

  function automatic void begin_move(logic [ptscu_pkg::CFG_W-1:0] half);
    half_len = (half == 0) ? 17'd1 : {1'b0, half};
    seg_idx = 0;
    start_segment();
  endfunction

  function automatic void track_move(int dx, int dz);
    logic [ptscu_pkg::POS_W-1:0] n;
    n = regs.auto_steps;
    seg_count = 0;
    if (dz != 0) begin
      tilt_pos = (dz > 0) ? tilt_pos + n : tilt_pos - n;
      add_segment(ptscu_pkg::AXIS_Z, (dz > 0) ? DIR_POS : DIR_NEG, {1'b0, n});
    end
    if (dx != 0) begin
      pan_pos = (dx > 0) ? pan_pos + n : pan_pos - n;
      add_segment(ptscu_pkg::AXIS_X, (dx > 0) ? DIR_POS : DIR_NEG, {1'b0, n});
    end
    begin_move(regs.auto_half);
  endfunction

  function automatic void manual_move(ptscu_pkg::axis_e axis, logic dir);
    seg_count = 0;
    add_segment(axis, dir, {1'b0, regs.manual_steps});
    begin_move(regs.manual_half);
  endfunction

  // The most negative count is treated as non-negative and homes left or down.
  function automatic void home_move();
    logic xn;
    logic zn;
    logic [ptscu_pkg::POS_W-1:0] xs;
    logic [ptscu_pkg::POS_W-1:0] zs;
    xn = pan_pos[ptscu_pkg::POS_W-1] && (pan_pos != POS_MOST_NEG);
    zn = tilt_pos[ptscu_pkg::POS_W-1] && (tilt_pos != POS_MOST_NEG);
    xs = xn ? (ptscu_pkg::POS_W'(0) - pan_pos) : pan_pos;
    zs = zn ? (ptscu_pkg::POS_W'(0) - tilt_pos) : tilt_pos;
    seg_count = 0;
    if (xn) add_segment(ptscu_pkg::AXIS_X, DIR_POS, {1'b0, xs});
    if (zn) add_segment(ptscu_pkg::AXIS_Z, DIR_POS, {1'b0, zs});
    if (!xn) add_segment(ptscu_pkg::AXIS_X, DIR_NEG, {1'b0, xs});
    if (!zn) add_segment(ptscu_pkg::AXIS_Z, DIR_NEG, {1'b0, zs});
    pan_pos = '0;
    tilt_pos = '0;
    begin_move(regs.home_half);
  endfunction

  function automatic void decode_cmd(logic [7:0] cmd);
    case (cmd)
      CMD_TILT_UP:    manual_move(ptscu_pkg::AXIS_Z, DIR_POS);
      CMD_TILT_DOWN:  manual_move(ptscu_pkg::AXIS_Z, DIR_NEG);
      CMD_PAN_LEFT:   manual_move(ptscu_pkg::AXIS_X, DIR_NEG);
      CMD_PAN_RIGHT:  manual_move(ptscu_pkg::AXIS_X, DIR_POS);
      CMD_UP_RIGHT:   track_move(1, 1);
      CMD_UP:         track_move(0, 1);
      CMD_UP_LEFT:    track_move(-1, 1);
      CMD_RIGHT:      track_move(1, 0);
      CMD_LEFT:       track_move(-1, 0);
      CMD_DOWN_RIGHT: track_move(1, -1);
      CMD_DOWN:       track_move(0, -1);
      CMD_DOWN_LEFT:  track_move(-1, -1);
      CMD_HOME:       home_move();
      CMD_LED_0:      led_on = LED_FIRST << 0;
      CMD_LED_1:      led_on = LED_FIRST << 1;
      CMD_LED_2:      led_on = LED_FIRST << 2;
      CMD_LED_3:      led_on = LED_FIRST << 3;
      CMD_LED_4:      led_on = LED_FIRST << 4;
      CMD_LED_5:      led_on = LED_FIRST << 5;
      CMD_LED_6:      led_on = LED_FIRST << 6;
      CMD_LED_7:      led_on = LED_FIRST << 7;
      CMD_LED_8:      led_on = LED_FIRST << 8;
      default: ;
    endcase
  endfunction

  function automatic ptscu_pkg::res_t advance_status(logic req, logic [7:0] cmd);
    ptscu_pkg::res_t r;
    ptscu_pkg::axis_e ax;
    logic dropped;
    dropped = 1'b0;
    if (req == REQ_TICK) begin
      if (moving) begin
        if (half_left != 0) half_left = half_left - 17'd1;
        if (half_left == 0) begin
          if (pulse_high) begin
            pulse_high = 1'b0;
            half_left = half_len;
          end else begin
            steps_left = steps_left - 17'd1;
            if (steps_left != 0) begin
              pulse_high = 1'b1;
              half_left = half_len;
            end else begin
              seg_idx++;
              start_segment();
            end
          end
        end
      end
    end else if (moving) begin
      dropped = 1'b1;
    end else begin
      decode_cmd(cmd);
    end
    ax = ptscu_pkg::AXIS_X;
    if (seg_idx < 2) ax = seg_axis[seg_idx];
    r.x_step = moving && (ax == ptscu_pkg::AXIS_X) && pulse_high;
    r.x_dir = pan_dir;
    r.z_step = moving && (ax == ptscu_pkg::AXIS_Z) && pulse_high;
    r.z_dir = tilt_dir;
    r.led = led_on;
    r.busy = moving;
    r.dropped = dropped;
    r.x_pos = pan_pos;
    r.z_pos = tilt_pos;
    return r;
  endfunction

  function automatic void queue_beat(logic req, logic [7:0] cmd);
    cmd_tick_t b;
    if (req == REQ_CMD) cmds_queued++;
    if (req == REQ_CMD || moving) live_beats++;
    b.req = req;
    b.cmd = cmd;
    b.want = advance_status(req, cmd);
    if (b.want.dropped) drops_queued++;
    cmd_tick_q.push_back(b);
  endfunction

  function automatic void finish_move(int noise_pct);
    while (moving) begin
      if ($urandom_range(99) < noise_pct) begin
        queue_beat(REQ_CMD, 8'($urandom_range(255)));
      end else begin
        queue_beat(REQ_TICK, 8'($urandom_range(255)));
      end
    end
  endfunction

  function automatic void queue_move(logic [7:0] cmd);
    queue_beat(REQ_CMD, cmd);
    finish_move(0);
  endfunction

  function automatic logic [7:0] pick_known_cmd();
    case ($urandom_range(21))
      0:  return CMD_TILT_UP;
      1:  return CMD_TILT_DOWN;
      2:  return CMD_PAN_LEFT;
      3:  return CMD_PAN_RIGHT;
      4:  return CMD_UP_RIGHT;
      5:  return CMD_UP;
      6:  return CMD_UP_LEFT;
      7:  return CMD_RIGHT;
      8:  return CMD_LEFT;
      9:  return CMD_DOWN_RIGHT;
      10: return CMD_DOWN;
      11: return CMD_DOWN_LEFT;
      12: return CMD_HOME;
      13: return CMD_LED_0;
      14: return CMD_LED_1;
      15: return CMD_LED_2;
      16: return CMD_LED_3;
      17: return CMD_LED_4;
      18: return CMD_LED_5;
      19: return CMD_LED_6;
      20: return CMD_LED_7;
      default: return CMD_LED_8;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic settle();
    while (cmd_tick_q.size() != 0 || in_valid_i || status_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [ptscu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ptscu_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
  endtask

  // Unused indexes get random data and must leave every register unchanged.
  task automatic write_regs(input ptscu_pkg::cfg_t c);
    settle();
    reg_write(ptscu_pkg::CFG_AUTO_STEPS, c.auto_steps);
    reg_write(ptscu_pkg::CFG_AUTO_HALF, c.auto_half);
    reg_write(ptscu_pkg::CFG_MANUAL_STEPS, c.manual_steps);
    reg_write(ptscu_pkg::CFG_MANUAL_HALF, c.manual_half);
    reg_write(ptscu_pkg::CFG_HOME_HALF, c.home_half);
    for (int i = int'(ptscu_pkg::CFG_HOME_HALF) + 1; i < (1 << ptscu_pkg::CFG_IDX_W); i++) begin
      reg_write(ptscu_pkg::CFG_IDX_W'(i), ptscu_pkg::CFG_W'($urandom));
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    regs = c;
    settings_applied++;
  endtask

  always @(negedge clk_i) begin : drive_beats
    cmd_tick_t nxt;
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (!in_valid_i || in_beat_taken) begin
      if (cmd_tick_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = cmd_tick_q.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.req;
        cmd_byte_i <= nxt.cmd;
        in_expected <= nxt.want;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_status
    ptscu_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        $display("%0t: result beat with no pending expectation", $time);
        error_count++;
      end else begin
        want = status_due.pop_front();
        status_checked++;
        check_field("x_step", 16'(want.x_step), 16'(x_step_o));
        check_field("x_dir", 16'(want.x_dir), 16'(x_dir_o));
        check_field("z_step", 16'(want.z_step), 16'(z_step_o));
        check_field("z_dir", 16'(want.z_dir), 16'(z_dir_o));
        check_field("led_pattern", 16'(want.led), 16'(led_pattern_o));
        check_field("busy_res", 16'(want.busy), 16'(busy_res_o));
        check_field("cmd_dropped", 16'(want.dropped), 16'(cmd_dropped_o));
        check_field("x_position", want.x_pos, x_position_o);
        check_field("z_position", want.z_pos, z_position_o);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) status_due.push_back(in_expected);
    in_beat_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : run_test
    ptscu_pkg::cfg_t c;
    int gap_pcts [4];
    int stall_pcts [4];
    int roll;
    int live_goal;
    gap_pcts = '{0, 56, 0, 14};
    stall_pcts = '{0, 0, 56, 14};
    reset_motion_model();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: idle ticks, unknown bytes and LED commands.
    queue_beat(REQ_TICK, BYTE_UNKNOWN_LOW);
    queue_beat(REQ_CMD, BYTE_UNKNOWN_LOW);
    queue_beat(REQ_CMD, CMD_LED_0);
    queue_beat(REQ_CMD, CMD_LED_8);
    queue_beat(REQ_CMD, BYTE_UNKNOWN_HIGH);
    queue_beat(REQ_TICK, BYTE_UNKNOWN_HIGH);

    c = '{auto_steps: 16'd3, auto_half: 16'd0, manual_steps: 16'd2, manual_half: 16'd1,
          home_half: 16'd2};
    write_regs(c);
    queue_move(CMD_TILT_UP);
    queue_move(CMD_TILT_DOWN);
    queue_move(CMD_PAN_LEFT);
    queue_move(CMD_PAN_RIGHT);
    queue_move(CMD_UP_RIGHT);
    queue_move(CMD_UP);
    queue_move(CMD_UP_LEFT);
    queue_move(CMD_RIGHT);
    queue_move(CMD_DOWN_RIGHT);
    queue_move(CMD_DOWN);
    queue_move(CMD_DOWN_LEFT);
    queue_move(CMD_DOWN_LEFT);
    queue_move(CMD_LEFT);
    queue_move(CMD_HOME);
    queue_move(CMD_DOWN_RIGHT);
    queue_move(CMD_HOME);
    queue_beat(REQ_CMD, BYTE_UNKNOWN_LOWER);

    c = '{auto_steps: 16'd4, auto_half: 16'd1, manual_steps: 16'd0, manual_half: 16'd0,
          home_half: 16'd1};
    write_regs(c);
    queue_move(CMD_PAN_RIGHT);
    queue_move(CMD_LEFT);
    queue_move(CMD_DOWN);
    queue_move(CMD_HOME);

    c = '{auto_steps: 16'd0, auto_half: 16'hFFFF, manual_steps: 16'd1,
          manual_half: 16'd2, home_half: 16'hFFFF};
    write_regs(c);
    queue_move(CMD_UP_LEFT);
    queue_move(CMD_TILT_DOWN);
    queue_move(CMD_HOME);

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 3; s++) begin
        c.auto_steps = ptscu_pkg::CFG_W'($urandom_range(6));
        c.auto_half = ptscu_pkg::CFG_W'($urandom_range(1, 3));
        c.manual_steps = ptscu_pkg::CFG_W'($urandom_range(6));
        c.manual_half = ptscu_pkg::CFG_W'($urandom_range(1, 3));
        c.home_half = ptscu_pkg::CFG_W'($urandom_range(1, 2));
        write_regs(c);
        gap_pct = gap_pcts[p];
        stall_pct = stall_pcts[p];
        live_goal = live_beats + BEATS_PER_SETTING;
        while (live_beats < live_goal) begin
          roll = $urandom_range(99);
          if (roll < 8) begin
            queue_beat(REQ_CMD, 8'($urandom_range(255)));
          end else if (roll < 12) begin
            queue_beat(REQ_TICK, 8'($urandom_range(255)));
          end else begin
            queue_beat(REQ_CMD, pick_known_cmd());
          end
          finish_move(3);
        end
      end
    end

    settle();
    if (status_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, status_due.size());
      error_count++;
    end
    $display("Checked %0d status beats from %0d command bytes, %0d dropped while busy,",
             status_checked, cmds_queued, drops_queued);
    $display("across %0d register settings and four handshake idling patterns.",
             settings_applied);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
